// ===== rtl/oaht_pkg.sv =====
// Package for the open-addressing hash table: field widths, operation,
// status and slot-state codes, the stored entry layout and default sizes.
// No dependencies.
`default_nettype none

package oaht_pkg;

    localparam int CAPACITY_DEF   = 31;
    localparam int STEP_PRIME_DEF = 13;

    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 5;
    localparam int ENTRY_CNT_W = 5;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (SLOT_W + DATA_W + ENTRY_CNT_W + 1);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_PROBE_MODE = 1'b0;
    localparam logic PROBE_MODE_RESET = 1'b1;

    // Key bits folded into the residues per cycle of the hash unit.
    localparam int HASH_BITS = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_INSERTED  = 3'd0,
        RES_REPLACED  = 3'd1,
        RES_FOUND     = 3'd2,
        RES_NOT_FOUND = 3'd3,
        RES_REMOVED   = 3'd4,
        RES_FULL      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_USED    = 2'd1,
        ST_DELETED = 2'd2
    } slot_state_t;

    typedef struct packed {
        slot_state_t             state;
        logic [KEY_W-1:0]        key;
        logic [DATA_W-1:0]       data;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/oaht_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
`default_nettype none

module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/oaht_hash.sv =====
// Hash unit: reduces a key modulo the capacity and modulo the step prime,
// a few bits per cycle, and gives the home slot and the probe step.
// Depends on oaht_pkg.
`default_nettype none

module oaht_hash #(
    parameter int CAPACITY   = oaht_pkg::CAPACITY_DEF,
    parameter int STEP_PRIME = oaht_pkg::STEP_PRIME_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [oaht_pkg::KEY_W-1:0]    key,
    input  wire logic                          probe_mode,
    output logic                               done,
    output logic [$clog2(CAPACITY)-1:0]        home,
    output logic [$clog2(CAPACITY)-1:0]        step
);

    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int PRIME_W     = $clog2(STEP_PRIME);
    localparam int STEP_W      = $clog2(STEP_PRIME + 1);
    localparam int CMP_W       = ((STEP_W > IDX_W) ? STEP_W : IDX_W) + 1;
    localparam int HASH_CYCLES = oaht_pkg::KEY_W / oaht_pkg::HASH_BITS;
    localparam int HC_W        = $clog2(HASH_CYCLES);

    logic [oaht_pkg::KEY_W-1:0] key_sh_reg;
    logic [oaht_pkg::KEY_W-1:0] key_sh_next;
    logic [IDX_W-1:0]           rc_reg;
    logic [IDX_W-1:0]           rc_next;
    logic [PRIME_W-1:0]         rp_reg;
    logic [PRIME_W-1:0]         rp_next;
    logic [HC_W-1:0]            cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [STEP_W-1:0]          step_full;
    logic [CMP_W-1:0]           step_ext;

    always_comb
    begin
        logic [IDX_W:0]     rc_t;
        logic [PRIME_W:0]   rp_t;
        logic [IDX_W-1:0]   rc;
        logic [PRIME_W-1:0] rp;
        rc = rc_reg;
        rp = rp_reg;
        for (int i = 0; i < oaht_pkg::HASH_BITS; i++)
        begin
            rc_t = {rc, key_sh_reg[oaht_pkg::KEY_W-1-i]};
            if (rc_t >= (IDX_W+1)'(CAPACITY))
            begin
                rc_t = rc_t - (IDX_W+1)'(CAPACITY);
            end
            rc = rc_t[IDX_W-1:0];
            rp_t = {rp, key_sh_reg[oaht_pkg::KEY_W-1-i]};
            if (rp_t >= (PRIME_W+1)'(STEP_PRIME))
            begin
                rp_t = rp_t - (PRIME_W+1)'(STEP_PRIME);
            end
            rp = rp_t[PRIME_W-1:0];
        end
        rc_next = rc;
        rp_next = rp;
        key_sh_next = key_sh_reg << oaht_pkg::HASH_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == HC_W'(HASH_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_sh_reg <= key;
            rc_reg     <= '0;
            rp_reg     <= '0;
        end
        else if (busy_reg)
        begin
            key_sh_reg <= key_sh_next;
            rc_reg     <= rc_next;
            rp_reg     <= rp_next;
        end
    end

    always_comb
    begin
        if (probe_mode)
        begin
            step_full = STEP_W'(STEP_PRIME) - STEP_W'(rp_reg);
        end
        else
        begin
            step_full = STEP_W'(1);
        end
        step_ext = CMP_W'(step_full);
        if (step_ext >= CMP_W'(CAPACITY))
        begin
            step_ext = step_ext - CMP_W'(CAPACITY);
        end
    end

    assign done = done_reg;
    assign home = rc_reg;
    assign step = step_ext[IDX_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/open_addressing_hash_table.sv =====
// Open-addressing hash table with linear or double-hashing probes.
// Requests arrive on the s_ stream (s_tuser: mode; s_tdata: key, data) and
// one result per request leaves on the m_ stream (m_tuser: status; m_tdata:
// slot, data_out, entry_count, over_half). probe_mode sits at APB address 0.
// After reset the table is swept to empty while s_tready stays low;
// configuration writes are taken throughout. One request is worked on
// at a time. The key is reduced modulo the capacity and the step prime
// four bits a cycle, then the probe reads one slot per cycle from the
// entry RAM, whose read is registered. An unknown mode skips the hash
// and the probe and goes straight to the result.
// The table is updated at the end of the probe, then the result moves to
// the output register. When the receiver stalls, the result waits there and
// the next request is still accepted and processed; it finishes into the
// output register once the earlier result has been taken.
// Depends on oaht_pkg, oaht_hash and oaht_ram.
`default_nettype none

module open_addressing_hash_table #(
    parameter int CAPACITY   = oaht_pkg::CAPACITY_DEF,
    parameter int STEP_PRIME = oaht_pkg::STEP_PRIME_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // key [31:0], data [63:32]
    input  wire logic [oaht_pkg::IN_TDATA_W-1:0]     s_tdata,
    // mode [1:0]
    input  wire logic [oaht_pkg::MODE_W-1:0]         s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // slot [4:0], data_out [36:5], entry_count [41:37], over_half [42], zero above
    output logic [oaht_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // status [2:0]
    output logic [oaht_pkg::STATUS_W-1:0]            m_tuser,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [oaht_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [oaht_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [oaht_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_HASH   = 5'b00100,
        S_PROBE  = 5'b01000,
        S_RESULT = 5'b10000
    } fsm_t;

    fsm_t                               fsm_reg;
    fsm_t                               fsm_next;
    logic [oaht_pkg::MODE_W-1:0]        mode_reg;
    logic [oaht_pkg::KEY_W-1:0]         key_reg;
    logic [oaht_pkg::DATA_W-1:0]        data_reg;
    logic                               take_req;
    logic [IDX_W-1:0]                   clr_cnt_reg;
    logic [IDX_W-1:0]                   clr_cnt_next;
    logic [IDX_W-1:0]                   pos_reg;
    logic [IDX_W-1:0]                   pos_next;
    logic [IDX_W-1:0]                   step_reg;
    logic [IDX_W-1:0]                   step_next;
    logic [CNT_W-1:0]                   issue_cnt_reg;
    logic [CNT_W-1:0]                   issue_cnt_next;
    logic [CNT_W-1:0]                   visit_cnt_reg;
    logic [CNT_W-1:0]                   visit_cnt_next;
    logic                               rd_pend_reg;
    logic                               rd_pend_next;
    logic [IDX_W-1:0]                   rd_pos_reg;
    logic [IDX_W-1:0]                   rd_pos_next;
    logic                               have_tomb_reg;
    logic                               have_tomb_next;
    logic [IDX_W-1:0]                   tomb_reg;
    logic [IDX_W-1:0]                   tomb_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    oaht_pkg::status_t                  res_status_reg;
    oaht_pkg::status_t                  res_status_next;
    logic [IDX_W-1:0]                   res_slot_reg;
    logic [IDX_W-1:0]                   res_slot_next;
    logic [oaht_pkg::DATA_W-1:0]        res_data_reg;
    logic [oaht_pkg::DATA_W-1:0]        res_data_next;
    logic                               out_load;
    logic                               out_valid_reg;
    oaht_pkg::status_t                  out_status_reg;
    logic [oaht_pkg::SLOT_W-1:0]        out_slot_reg;
    logic [oaht_pkg::DATA_W-1:0]        out_data_reg;
    logic [oaht_pkg::ENTRY_CNT_W-1:0]   out_count_reg;
    logic                               out_half_reg;
    logic                               probe_mode_reg;
    logic                               hash_start;
    logic                               hash_done;
    logic [IDX_W-1:0]                   hash_home;
    logic [IDX_W-1:0]                   hash_step;
    logic                               ram_wr_en;
    logic [IDX_W-1:0]                   ram_wr_addr;
    oaht_pkg::entry_t                   ram_wr_data;
    logic                               ram_rd_en;
    logic [IDX_W-1:0]                   ram_rd_addr;
    oaht_pkg::entry_t                   ram_rd_data;
    logic [IDX_W:0]                     pos_sum;
    logic [IDX_W-1:0]                   pos_adv;

    oaht_hash #(
        .CAPACITY   (CAPACITY),
        .STEP_PRIME (STEP_PRIME)
    ) u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (hash_start),
        .key        (s_tdata[oaht_pkg::KEY_W-1:0]),
        .probe_mode (probe_mode_reg),
        .done       (hash_done),
        .home       (hash_home),
        .step       (hash_step)
    );

    oaht_ram #(
        .WIDTH (($bits(oaht_pkg::entry_t))),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        pos_sum = {1'b0, pos_reg} + {1'b0, step_reg};
        if (pos_sum >= (IDX_W+1)'(CAPACITY))
        begin
            pos_sum = pos_sum - (IDX_W+1)'(CAPACITY);
        end
        pos_adv = pos_sum[IDX_W-1:0];
    end

    always_comb
    begin
        oaht_pkg::entry_t ent;
        logic             key_hit;
        logic             last_visit;
        logic             exh_tomb;
        logic [IDX_W-1:0] tomb_sel;

        fsm_next        = fsm_reg;
        take_req        = 1'b0;
        hash_start      = 1'b0;
        clr_cnt_next    = clr_cnt_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        issue_cnt_next  = issue_cnt_reg;
        visit_cnt_next  = visit_cnt_reg;
        rd_pend_next    = 1'b0;
        rd_pos_next     = rd_pos_reg;
        have_tomb_next  = have_tomb_reg;
        tomb_next       = tomb_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_data_next   = res_data_reg;
        out_load        = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = '0;
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = pos_reg;

        ent        = ram_rd_data;
        key_hit    = (ent.state == oaht_pkg::ST_USED) && (ent.key == key_reg);
        last_visit = (visit_cnt_reg == CNT_W'(CAPACITY - 1));
        exh_tomb   = have_tomb_reg || (ent.state == oaht_pkg::ST_DELETED);
        tomb_sel   = have_tomb_reg ? tomb_reg : rd_pos_reg;

        case (fsm_reg)
            S_CLEAR:
            begin
                ram_wr_en         = 1'b1;
                ram_wr_addr       = clr_cnt_reg;
                ram_wr_data.state = oaht_pkg::ST_EMPTY;
                if (clr_cnt_reg == IDX_W'(CAPACITY - 1))
                begin
                    fsm_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    take_req = 1'b1;
                    if ((s_tuser == oaht_pkg::MODE_INSERT) ||
                        (s_tuser == oaht_pkg::MODE_FIND) ||
                        (s_tuser == oaht_pkg::MODE_REMOVE))
                    begin
                        hash_start = 1'b1;
                        fsm_next   = S_HASH;
                    end
                    else
                    begin
                        res_status_next = oaht_pkg::RES_NOT_FOUND;
                        res_slot_next   = '0;
                        res_data_next   = '0;
                        fsm_next        = S_RESULT;
                    end
                end
            end

            S_HASH:
            begin
                if (hash_done)
                begin
                    pos_next       = hash_home;
                    step_next      = hash_step;
                    issue_cnt_next = '0;
                    visit_cnt_next = '0;
                    have_tomb_next = 1'b0;
                    tomb_next      = '0;
                    fsm_next       = S_PROBE;
                end
            end

            S_PROBE:
            begin
                if (issue_cnt_reg != CNT_W'(CAPACITY))
                begin
                    ram_rd_en      = 1'b1;
                    pos_next       = pos_adv;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    rd_pend_next   = 1'b1;
                    rd_pos_next    = pos_reg;
                end
                if (rd_pend_reg)
                begin
                    visit_cnt_next = visit_cnt_reg + 1'b1;
                    res_data_next  = '0;
                    case (mode_reg)
                        oaht_pkg::MODE_INSERT:
                        begin
                            if ((ent.state == oaht_pkg::ST_DELETED) && !have_tomb_reg)
                            begin
                                have_tomb_next = 1'b1;
                                tomb_next      = rd_pos_reg;
                            end
                            if ((ent.state == oaht_pkg::ST_EMPTY) || (last_visit && exh_tomb &&
                                !key_hit))
                            begin
                                ram_wr_en         = 1'b1;
                                ram_wr_addr       = tomb_sel;
                                ram_wr_data.state = oaht_pkg::ST_USED;
                                ram_wr_data.key   = key_reg;
                                ram_wr_data.data  = data_reg;
                                count_next        = count_reg + 1'b1;
                                res_status_next   = oaht_pkg::RES_INSERTED;
                                res_slot_next     = tomb_sel;
                                fsm_next          = S_RESULT;
                            end
                            else if (key_hit)
                            begin
                                ram_wr_en         = 1'b1;
                                ram_wr_addr       = rd_pos_reg;
                                ram_wr_data.state = oaht_pkg::ST_USED;
                                ram_wr_data.key   = key_reg;
                                ram_wr_data.data  = data_reg;
                                res_status_next   = oaht_pkg::RES_REPLACED;
                                res_slot_next     = rd_pos_reg;
                                fsm_next          = S_RESULT;
                            end
                            else if (last_visit)
                            begin
                                res_status_next = oaht_pkg::RES_FULL;
                                res_slot_next   = '0;
                                fsm_next        = S_RESULT;
                            end
                        end

                        oaht_pkg::MODE_FIND, oaht_pkg::MODE_REMOVE:
                        begin
                            if (ent.state == oaht_pkg::ST_EMPTY)
                            begin
                                res_status_next = oaht_pkg::RES_NOT_FOUND;
                                res_slot_next   = '0;
                                fsm_next        = S_RESULT;
                            end
                            else if (key_hit)
                            begin
                                res_slot_next = rd_pos_reg;
                                fsm_next      = S_RESULT;
                                if (mode_reg == oaht_pkg::MODE_FIND)
                                begin
                                    res_status_next = oaht_pkg::RES_FOUND;
                                    res_data_next   = ent.data;
                                end
                                else
                                begin
                                    ram_wr_en         = 1'b1;
                                    ram_wr_addr       = rd_pos_reg;
                                    ram_wr_data.state = oaht_pkg::ST_DELETED;
                                    ram_wr_data.key   = ent.key;
                                    ram_wr_data.data  = ent.data;
                                    if (count_reg != '0)
                                    begin
                                        count_next = count_reg - 1'b1;
                                    end
                                    res_status_next = oaht_pkg::RES_REMOVED;
                                end
                            end
                            else if (last_visit)
                            begin
                                res_status_next = oaht_pkg::RES_NOT_FOUND;
                                res_slot_next   = '0;
                                fsm_next        = S_RESULT;
                            end
                        end

                        default:
                        begin
                            res_status_next = oaht_pkg::RES_NOT_FOUND;
                            res_slot_next   = '0;
                            fsm_next        = S_RESULT;
                        end
                    endcase
                    if (fsm_next == S_RESULT)
                    begin
                        rd_pend_next = 1'b0;
                    end
                end
            end

            S_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    fsm_next = S_IDLE;
                end
            end

            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= S_CLEAR;
            clr_cnt_reg    <= '0;
            issue_cnt_reg  <= '0;
            visit_cnt_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            have_tomb_reg  <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            probe_mode_reg <= oaht_pkg::PROBE_MODE_RESET;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            clr_cnt_reg   <= clr_cnt_next;
            issue_cnt_reg <= issue_cnt_next;
            visit_cnt_reg <= visit_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            have_tomb_reg <= have_tomb_next;
            count_reg     <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (psel && penable && pwrite && (paddr[2] == oaht_pkg::REG_PROBE_MODE))
            begin
                probe_mode_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            mode_reg <= s_tuser;
            key_reg  <= s_tdata[oaht_pkg::KEY_W-1:0];
            data_reg <= s_tdata[oaht_pkg::KEY_W +: oaht_pkg::DATA_W];
        end
        pos_reg        <= pos_next;
        step_reg       <= step_next;
        rd_pos_reg     <= rd_pos_next;
        tomb_reg       <= tomb_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_data_reg   <= res_data_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= oaht_pkg::SLOT_W'(res_slot_reg);
            out_data_reg   <= res_data_reg;
            out_count_reg  <= oaht_pkg::ENTRY_CNT_W'(count_reg);
            out_half_reg   <= ({count_reg, 1'b0} > (CNT_W+1)'(CAPACITY));
        end
    end

    assign s_tready = (fsm_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{oaht_pkg::OUT_PAD_W{1'b0}}, out_half_reg, out_count_reg,
                       out_data_reg, out_slot_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == oaht_pkg::REG_PROBE_MODE) ?
                      oaht_pkg::APB_DATA_W'(probe_mode_reg) : '0;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for open_addressing_hash_table: a directed table of requests,
// then random request phases under both probe modes, every result checked against a
// behavioural model of the table or a fixed outcome. Depends on oaht_pkg and the RTL of the block.

module tb_top;
    import oaht_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int STEP_PRIME   = STEP_PRIME_DEF;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE       = CAPACITY + 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int POOL_SIZE    = 44;
    localparam int MAX_IDLE     = 13;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] PROBE_MODE_ADDR = APB_ADDR_W'(4 * int'(REG_PROBE_MODE));

    localparam int DOUT_LSB  = SLOT_W;
    localparam int COUNT_LSB = SLOT_W + DATA_W;
    localparam int OVER_BIT  = SLOT_W + DATA_W + ENTRY_CNT_W;

    typedef struct packed {
        status_t                status;
        logic [SLOT_W-1:0]      slot;
        logic [DATA_W-1:0]      dout;
        logic [ENTRY_CNT_W-1:0] count;
        logic                   over;
    } outcome_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        logic              known;
        outcome_t          want;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [MODE_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    slot_state_t       model_state [CAPACITY];
    logic [KEY_W-1:0]  model_key [CAPACITY];
    logic [DATA_W-1:0] model_data [CAPACITY];
    int                model_used;
    logic              model_probe;

    outcome_t          awaited[$];
    row_t              directed_rows[$];
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];
    int                mismatches = 0;
    int                requests_sent = 0;
    int                results_taken = 0;
    int                cycle_count = 0;
    int                seen_status [8];
    bit                send_calm = 1'b0;
    bit                take_calm = 1'b0;

    open_addressing_hash_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding", $time, awaited.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic int unsigned probe_stride(input logic [KEY_W-1:0] key);
        if (!model_probe)
            return 1;
        return STEP_PRIME - (key % STEP_PRIME);
    endfunction

    function automatic bit locate_key(input logic [KEY_W-1:0] key, output int unsigned where);
        int unsigned pos;
        int unsigned stride;
        pos = key % CAPACITY;
        stride = probe_stride(key);
        where = 0;
        for (int n = 0; n < CAPACITY; n++)
        begin
            if (model_state[pos] == ST_EMPTY)
                return 1'b0;
            if (model_state[pos] == ST_USED && model_key[pos] == key)
            begin
                where = pos;
                return 1'b1;
            end
            pos = (pos + stride) % CAPACITY;
        end
        return 1'b0;
    endfunction

    task automatic table_apply(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                               input logic [DATA_W-1:0] data, output outcome_t res);
        int unsigned pos;
        int unsigned stride;
        int unsigned tomb;
        int unsigned target;
        bit have_tomb;
        bit have_target;
        bit replaced;
        res.status = RES_NOT_FOUND;
        res.slot = '0;
        res.dout = '0;
        case (mode)
            MODE_INSERT:
            begin
                pos = key % CAPACITY;
                stride = probe_stride(key);
                have_tomb = 1'b0;
                have_target = 1'b0;
                replaced = 1'b0;
                tomb = 0;
                target = 0;
                for (int n = 0; n < CAPACITY && !have_target && !replaced; n++)
                begin
                    if (model_state[pos] == ST_EMPTY)
                    begin
                        target = have_tomb ? tomb : pos;
                        have_target = 1'b1;
                    end
                    else if (model_state[pos] == ST_USED)
                    begin
                        if (model_key[pos] == key)
                        begin
                            model_data[pos] = data;
                            res.status = RES_REPLACED;
                            res.slot = SLOT_W'(pos);
                            replaced = 1'b1;
                        end
                    end
                    else if (!have_tomb)
                    begin
                        have_tomb = 1'b1;
                        tomb = pos;
                    end
                    pos = (pos + stride) % CAPACITY;
                end
                // With the probe exhausted, a tombstone met on the way still takes the entry.
                if (!replaced && !have_target && have_tomb)
                begin
                    target = tomb;
                    have_target = 1'b1;
                end
                if (!replaced && have_target)
                begin
                    model_state[target] = ST_USED;
                    model_key[target] = key;
                    model_data[target] = data;
                    model_used++;
                    res.status = RES_INSERTED;
                    res.slot = SLOT_W'(target);
                end
                else if (!replaced)
                    res.status = RES_FULL;
            end
            MODE_FIND:
            begin
                if (locate_key(key, pos))
                begin
                    res.status = RES_FOUND;
                    res.slot = SLOT_W'(pos);
                    res.dout = model_data[pos];
                end
            end
            MODE_REMOVE:
            begin
                if (locate_key(key, pos))
                begin
                    model_state[pos] = ST_DELETED;
                    if (model_used > 0)
                        model_used--;
                    res.status = RES_REMOVED;
                    res.slot = SLOT_W'(pos);
                end
            end
            default:
            begin
            end
        endcase
        res.count = ENTRY_CNT_W'(model_used);
        res.over = (2 * model_used > CAPACITY);
    endtask

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_row(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                           input logic [DATA_W-1:0] data);
        row_t row;
        row = '0;
        row.mode = mode;
        row.key = key;
        row.data = data;
        directed_rows.push_back(row);
    endtask

    task automatic add_known(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                             input logic [DATA_W-1:0] data, input status_t status,
                             input int slot, input logic [DATA_W-1:0] dout, input int count,
                             input bit over);
        row_t row;
        row.mode = mode;
        row.key = key;
        row.data = data;
        row.known = 1'b1;
        row.want.status = status;
        row.want.slot = SLOT_W'(slot);
        row.want.dout = dout;
        row.want.count = ENTRY_CNT_W'(count);
        row.want.over = over;
        directed_rows.push_back(row);
    endtask

    task automatic issue_request(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                                 input logic [DATA_W-1:0] data, input bit known,
                                 input outcome_t want);
        int gap;
        outcome_t predicted;
        gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {data, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        table_apply(mode, key, data, predicted);
        awaited.push_back(known ? want : predicted);
        requests_sent++;
        if ($urandom_range(0, 15) == 0)
            send_calm = !send_calm;
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic check_probe_mode(input logic want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= PROBE_MODE_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        compare_field("probe_mode readback", DATA_W'(want), prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_probe_mode(input logic value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PROBE_MODE_ADDR;
        pwdata <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        model_probe = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        check_probe_mode(value);
    endtask

    task automatic run_phase(input int count, input int w_insert, input int w_find,
                             input int w_remove);
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        outcome_t          none;
        int                pick;
        none = '0;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < w_insert)
                mode = MODE_INSERT;
            else if (pick < w_insert + w_find)
                mode = MODE_FIND;
            else if (pick < w_insert + w_find + w_remove)
                mode = MODE_REMOVE;
            else
                mode = MODE_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 85)
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (pick < 95)
                key = $urandom;
            else
                key = $urandom_range(0, 1) ? '1 : '0;
            data = ($urandom_range(0, 15) == 0) ? '1 : DATA_W'($urandom);
            issue_request(mode, key, data, 1'b0, none);
        end
    endtask

    initial
    begin : result_sink
        int stall;
        outcome_t want;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = take_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            results_taken++;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result, expected nothing, actual status %0d tdata %h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end
            else
            begin
                want = awaited.pop_front();
                compare_field("status", DATA_W'(want.status), DATA_W'(m_tuser));
                compare_field("slot", DATA_W'(want.slot), DATA_W'(m_tdata[SLOT_W-1:0]));
                compare_field("data_out", want.dout, m_tdata[DOUT_LSB +: DATA_W]);
                compare_field("entry_count", DATA_W'(want.count),
                              DATA_W'(m_tdata[COUNT_LSB +: ENTRY_CNT_W]));
                compare_field("over_half", DATA_W'(want.over), DATA_W'(m_tdata[OVER_BIT]));
                compare_field("tdata padding", '0,
                              DATA_W'(m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]));
            end
            if (!$isunknown(m_tuser))
                seen_status[m_tuser]++;
            if ($urandom_range(0, 15) == 0)
                take_calm = !take_calm;
        end
    end

    initial
    begin : stimulus
        row_t row;
        for (int i = 0; i < CAPACITY; i++)
        begin
            model_state[i] = ST_EMPTY;
            model_key[i] = '0;
            model_data[i] = '0;
        end
        for (int i = 0; i < 8; i++)
            seen_status[i] = 0;
        model_used = 0;
        model_probe = PROBE_MODE_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_probe_mode(PROBE_MODE_RESET);

        // Empty table under double hashing: misses, the unused mode, extremes of key and
        // data, replacement, collisions on slot zero, tombstone skipping and reuse.
        add_known(MODE_FIND, 32'h0, 32'h0, RES_NOT_FOUND, 0, 32'h0, 0, 1'b0);
        add_known(MODE_REMOVE, '1, '1, RES_NOT_FOUND, 0, 32'h0, 0, 1'b0);
        add_known(MODE_UNUSED, 32'h5, '1, RES_NOT_FOUND, 0, 32'h0, 0, 1'b0);
        add_known(MODE_INSERT, 32'h0, '1, RES_INSERTED, 0, 32'h0, 1, 1'b0);
        add_row(MODE_INSERT, '1, 32'h0);
        add_known(MODE_FIND, 32'h0, 32'h0, RES_FOUND, 0, '1, 2, 1'b0);
        add_known(MODE_INSERT, 32'h0, 32'h1234_5678, RES_REPLACED, 0, 32'h0, 2, 1'b0);
        add_row(MODE_FIND, 32'h0, '1);
        add_row(MODE_INSERT, 32'd31, 32'hA5A5_A5A5);
        add_row(MODE_INSERT, 32'd62, 32'h5A5A_5A5A);
        add_known(MODE_REMOVE, 32'h0, 32'h0, RES_REMOVED, 0, 32'h0, 3, 1'b0);
        add_row(MODE_FIND, 32'd31, 32'h0);
        add_row(MODE_INSERT, 32'd93, 32'h0);
        add_row(MODE_FIND, 32'd93, 32'h0);
        add_row(MODE_REMOVE, 32'd31, 32'h0);
        add_row(MODE_FIND, 32'd31, 32'h0);
        add_row(MODE_REMOVE, 32'd31, 32'h0);
        add_row(MODE_INSERT, 32'h8000_0000, 32'h5555_5555);
        add_row(MODE_FIND, 32'h8000_0000, 32'h0);
        add_row(MODE_UNUSED, '1, '1);
        add_row(MODE_FIND, '1, 32'h0);
        add_row(MODE_REMOVE, 32'd62, 32'h0);
        add_row(MODE_INSERT, 32'd62, 32'hAAAA_AAAA);
        add_row(MODE_FIND, 32'd62, 32'h0);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            issue_request(row.mode, row.key, row.data, row.known, row.want);
        end
        drain_and_settle();

        // Half the pool shares residues modulo the capacity, so probes run long.
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = (i % 2 == 0) ? KEY_W'($urandom)
                          : KEY_W'($urandom_range(0, 138000000) * CAPACITY
                                   + $urandom_range(0, 2));

        // Fill to overflow, churn with tombstones, drain, then fill again.
        set_probe_mode(1'b0);
        run_phase(110, 70, 15, 10);
        drain_and_settle();
        set_probe_mode(1'b1);
        run_phase(100, 40, 25, 30);
        drain_and_settle();
        set_probe_mode(1'b0);
        run_phase(90, 30, 25, 40);
        drain_and_settle();
        set_probe_mode(1'b1);
        run_phase(100, 70, 15, 10);
        drain_and_settle();

        $display("Ran %0d requests over both probe modes, %0d results in %0d cycles.",
                 requests_sent, results_taken, cycle_count);
        $display("Inserted %0d, replaced %0d, found %0d, not found %0d, removed %0d, full %0d.",
                 seen_status[RES_INSERTED], seen_status[RES_REPLACED], seen_status[RES_FOUND],
                 seen_status[RES_NOT_FOUND], seen_status[RES_REMOVED], seen_status[RES_FULL]);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
